// ----- sv/lrucl_pkg.sv -----
`default_nettype none

package lrucl_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int POS_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // fixed field widths at the ports
    localparam int KEY_W  = 32;
    localparam int HPOS_W = 4;
    localparam int OCC_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/lrucl_ctrl.sv -----
`default_nettype none

module lrucl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output lrucl_pkg::t_cmd    o_cmd
);
    import lrucl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lrucl_dp.sv -----
`default_nettype none

module lrucl_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lrucl_pkg::t_cmd               i_cmd,
    input  wire logic [lrucl_pkg::CAP_W-1:0]   i_capacity,
    input  wire logic signed [lrucl_pkg::KEY_W-1:0] i_key,
    output logic                               o_valid,
    output logic                               o_rejected,
    output logic                               o_hit,
    output logic [lrucl_pkg::HPOS_W-1:0]       o_hit_position,
    output logic                               o_evicted,
    output logic signed [lrucl_pkg::KEY_W-1:0] o_evicted_key,
    output logic [lrucl_pkg::OCC_W-1:0]        o_occupancy
);
    import lrucl_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_ent [DEPTH];
    logic [CNT_W-1:0]    r_count;

    // match-stage results
    logic                r_rej;
    logic                r_hit;
    logic [POS_W-1:0]    r_pos;
    logic                r_evict;
    logic [KEY_BITS-1:0] r_ekey;
    logic [POS_W-1:0]    r_limit;

    // output registers
    logic                r_valid;
    logic                r_o_rej;
    logic                r_o_hit;
    logic [POS_W-1:0]    r_o_pos;
    logic                r_o_evict;
    logic [KEY_BITS-1:0] r_o_ekey;
    logic [CNT_W-1:0]    r_o_occ;

    logic [CNT_W-1:0]    cap_sat;
    logic [DEPTH-1:0]    match_vec;
    logic                found;
    logic [POS_W-1:0]    found_pos;
    logic                evict_now;
    logic [CNT_W-1:0]    tail_idx;
    logic [CNT_W-1:0]    n_count;

    always_comb begin
        if (i_capacity > CAP_W'(DEPTH)) begin
            cap_sat = CNT_W'(DEPTH);
        end else begin
            cap_sat = CNT_W'(i_capacity);
        end
    end

    // parallel compare against all held keys
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_vec[i] = (r_ent[i] == r_key) && (CNT_W'(i) < r_count);
        end
    end

    // first match wins (most recent)
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                found     = 1'b1;
                found_pos = POS_W'(i);
            end
        end
    end

    assign evict_now = !found && (r_count >= cap_sat);
    assign tail_idx  = r_count - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key[KEY_BITS-1:0];
        end
        if (i_cmd.match) begin
            r_rej   <= (cap_sat == '0);
            r_hit   <= found;
            r_pos   <= found_pos;
            r_evict <= evict_now;
            r_ekey  <= r_ent[tail_idx[POS_W-1:0]];
            // highest entry that takes its neighbor's key
            if (found) begin
                r_limit <= found_pos;
            end else if (evict_now) begin
                r_limit <= tail_idx[POS_W-1:0];
            end else begin
                r_limit <= r_count[POS_W-1:0];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (!r_hit && !r_evict) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // shift update of the recency line
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_rej) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (POS_W'(i) <= r_limit) begin
                    r_ent[i] <= r_ent[i-1];
                end
            end
            r_ent[0] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.update && !r_rej) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_o_rej   <= r_rej;
            r_o_hit   <= !r_rej && r_hit;
            r_o_pos   <= (!r_rej && r_hit) ? r_pos : '0;
            r_o_evict <= !r_rej && r_evict;
            r_o_ekey  <= (!r_rej && r_evict) ? r_ekey : '0;
            r_o_occ   <= r_rej ? r_count : n_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_rejected     = r_o_rej;
    assign o_hit          = r_o_hit;
    assign o_hit_position = HPOS_W'(r_o_pos);
    assign o_evicted      = r_o_evict;
    assign o_evicted_key  = KEY_W'(r_o_ekey);
    assign o_occupancy    = OCC_W'(r_o_occ);

endmodule

`default_nettype wire

// ----- sv/lru_cache_lookup_core.sv -----
`default_nettype none

// Fully associative LRU key store, 16 keys deep, most recent at position 0.
// A lookup is taken when start is high and busy is low. The accepting cycle
// loads the key, the match state compares it against all held keys in
// parallel and picks the most recent match, and the update state shifts the
// recency line by one place and writes the key at the front. busy is high in
// the match and update states. The result is shown on the o_ ports for
// exactly one cycle, flagged by o_valid, in the first cycle with busy low
// again; the receiver cannot stall it, so it must take every transfer as it
// comes. No new lookup is taken while busy; a new lookup may start in that
// same cycle.
// Capacity (APB register at address 0, reset 16, values above 16 act as 16)
// must only be written while the block is idle. Capacity zero rejects lookups
// without touching the store. The key store has no reset; only entries below
// the occupancy count are ever compared or reported.
module lru_cache_lookup_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // lookup command
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [lrucl_pkg::KEY_W-1:0]  i_key,
    // result
    output logic                                     o_valid,
    output logic                                     o_rejected,
    output logic                                     o_hit,
    output logic [lrucl_pkg::HPOS_W-1:0]             o_hit_position,
    output logic                                     o_evicted,
    output logic signed [lrucl_pkg::KEY_W-1:0]       o_evicted_key,
    output logic [lrucl_pkg::OCC_W-1:0]              o_occupancy,
    // APB configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import lrucl_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;
    t_cmd             cmd;

    // write completes in the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = 32'(r_capacity);
        end
    end

    // sequencing: idle -> match -> update
    lrucl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // key line, compare, shift and result registers
    lrucl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_capacity     (r_capacity),
        .i_key          (i_key),
        .o_valid        (o_valid),
        .o_rejected     (o_rejected),
        .o_hit          (o_hit),
        .o_hit_position (o_hit_position),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Bench for lru_cache_lookup_core: drives lookups through the start/busy
// handshake and capacity writes over APB. A behavioral mirror of the recency
// line predicts every result, which the monitor compares field by field.
module tb;
    import lrucl_pkg::*;

    // capacity register and one unmapped register slot, both by index
    localparam logic [2:0] CAP_ADDR      = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = {~REG_CAPACITY, 2'b00};
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_ITEMS  = 1250;

    typedef struct packed {
        logic              rejected;
        logic              hit;
        logic [HPOS_W-1:0] hit_position;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [OCC_W-1:0]  occupancy;
    } t_lookup_result;

    // Mirror of the recency line: predicts one result per accepted lookup and
    // holds the predictions until the block reports them.
    class t_lru_mirror;
        logic [KEY_W-1:0] line [DEPTH];
        int unsigned      held;
        int unsigned      cap;
        int unsigned      errors;
        t_lookup_result   pending [$];

        function new();
            held   = 0;
            cap    = 16;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == CAP_ADDR)
                cap = 32'(data[CAP_W-1:0]);
        endfunction

        function int unsigned limit();
            return (cap > DEPTH) ? DEPTH : cap;
        endfunction

        function void note_lookup(logic [KEY_W-1:0] key);
            t_lookup_result r;
            int unsigned    pos;
            bit             found;
            r     = '0;
            pos   = 0;
            found = 0;
            if (limit() == 0) begin
                r.rejected = 1'b1;
            end else begin
                for (int i = 0; i < held; i++) begin
                    if (!found && line[i] == key) begin
                        found = 1;
                        pos   = i;
                    end
                end
                if (found) begin
                    r.hit          = 1'b1;
                    r.hit_position = pos[HPOS_W-1:0];
                    for (int i = pos; i > 0; i--)
                        line[i] = line[i-1];
                end else begin
                    // at or over the limit: drop the tail first
                    if (held >= limit()) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = line[held-1];
                        held--;
                    end
                    for (int i = held; i > 0; i--)
                        line[i] = line[i-1];
                    held++;
                end
                line[0] = key;
            end
            r.occupancy = held[OCC_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_lookup_result got);
            t_lookup_result want;
            if (pending.size() == 0) begin
                $error("result with no lookup outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.rejected != want.rejected) begin
                $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
                errors++;
            end
            if (got.hit != want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.hit_position != want.hit_position) begin
                $error("hit_position: expected %0d, actual %0d",
                       want.hit_position, got.hit_position);
                errors++;
            end
            if (got.evicted != want.evicted) begin
                $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key != want.evicted_key) begin
                $error("evicted_key: expected %h, actual %h",
                       want.evicted_key, got.evicted_key);
                errors++;
            end
            if (got.occupancy != want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [KEY_W-1:0]  i_key   = '0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;

    logic              busy;
    logic              o_valid;
    logic              o_rejected;
    logic              o_hit;
    logic [HPOS_W-1:0] o_hit_position;
    logic              o_evicted;
    logic [KEY_W-1:0]  o_evicted_key;
    logic [OCC_W-1:0]  o_occupancy;
    logic [31:0]       prdata;
    logic              pready;

    t_lru_mirror mirror = new();
    int unsigned cycles = 0;

    lru_cache_lookup_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_key          (i_key),
        .o_valid        (o_valid),
        .o_rejected     (o_rejected),
        .o_hit          (o_hit),
        .o_hit_position (o_hit_position),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .o_occupancy    (o_occupancy),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is a transfer. All reads
    // here see the values from before this edge.
    always @(posedge i_clk) begin : result_monitor
        t_lookup_result got;
        if (i_rst_n && o_valid) begin
            got.rejected     = o_rejected;
            got.hit          = o_hit;
            got.hit_position = o_hit_position;
            got.evicted      = o_evicted;
            got.evicted_key  = o_evicted_key;
            got.occupancy    = o_occupancy;
            mirror.check_result(got);
        end
    end

    // One lookup. Called right after an edge. With no gap, start stays high
    // from the previous transfer and only the key changes; otherwise start
    // drops at this edge and rises again after the gap.
    task automatic send_key(logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;    // keep some back-to-back runs
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_key <= key;
        do @(posedge i_clk); while (busy);
        mirror.note_lookup(key);
    endtask

    // Stop issuing and wait until every predicted result has arrived, then
    // a few more cycles so the block is fully back in idle.
    task automatic drain();
        start <= 1'b0;
        while (mirror.pending.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready. Only called idle.
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_capacity(int unsigned value);
        drain();
        // upper data bits are random; only the low five bits count
        reg_write(CAP_ADDR, {27'($urandom_range(0, 32'h07FF_FFFF)), value[CAP_W-1:0]});
    endtask

    initial begin : stimulus
        int unsigned      counted;
        int unsigned      phase;
        int unsigned      n_items;
        int unsigned      pool;
        logic [KEY_W-1:0] base;
        int unsigned      fixed_caps [6];

        fixed_caps = '{16, 1, 2, 0, 31, 17};
        counted = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: key extremes at reset capacity, then a hit three deep.
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h8000_0000);
        send_key(32'h7FFF_FFFF);
        send_key(32'h0000_0000);

        // Capacity lowered under occupancy: the miss swaps the tail out and
        // occupancy holds; a key held past the limit still hits.
        set_capacity(2);
        send_key(32'h5555_5555);
        send_key(32'h8000_0000);

        // Zero capacity rejects; a write to an unmapped slot changes nothing.
        set_capacity(0);
        drain();
        reg_write(UNMAPPED_ADDR, 32'd16);
        send_key(32'hAAAA_AAAA);
        send_key(32'h0000_0000);

        // Capacity above the depth acts as full depth: sixteen fresh keys
        // push out the old ones, then the oldest fresh key hits at the tail.
        set_capacity(31);
        for (int i = 0; i < DEPTH; i++)
            send_key(32'h0101_0000 + i);
        send_key(32'h0101_0000);

        // Random phases. Keys come mostly from a small window sized near the
        // capacity so hits, reordering and evictions all happen often; the
        // rest are fully random. Rejected lookups are not counted.
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            set_capacity((phase < 6) ? fixed_caps[phase] : $urandom_range(0, 31));
            n_items = (mirror.limit() == 0) ? 6 : $urandom_range(30, 80);
            pool    = mirror.limit() + $urandom_range(1, 4);
            base    = $urandom();
            for (int i = 0; i < n_items; i++) begin
                // hold off once per phase until everything is back
                if (i == n_items / 2)
                    drain();
                if ($urandom_range(0, 4) == 0)
                    send_key($urandom());
                else
                    send_key(base + $urandom_range(0, pool - 1));
                if (mirror.limit() != 0)
                    counted++;
            end
            phase++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
